// ----- hw/rtl/bldrv_pkg.sv -----
package bldrv_pkg;

	localparam int NOW_W      = 32;
	localparam int SLIDER_W   = 4;
	localparam int LEVEL_W    = 8;
	localparam int MASK_W     = 10;
	localparam int PER_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_BARS   = 10;

	// Q1.16 ramp position and eased value, 0 .. 1.0 inclusive
	localparam int Q_W        = 17;
	localparam int MUL_A_W    = 17;
	localparam int MUL_B_W    = 18;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W + 1;

	localparam logic [Q_W-1:0]     Q_ONE     = Q_W'(65536);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = '0;

	localparam logic [PER_W-1:0]    SETTLE_RST = PER_W'(500);
	localparam logic [PER_W-1:0]    SLOW_RST   = PER_W'(1000);
	localparam logic [PER_W-1:0]    MID_RST    = PER_W'(500);
	localparam logic [PER_W-1:0]    FAST_RST   = PER_W'(250);
	localparam logic [SLIDER_W-1:0] MID_TH_RST = SLIDER_W'(6);
	localparam logic [SLIDER_W-1:0] HI_TH_RST  = SLIDER_W'(7);

	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_TH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HI_TH  = 3'd5;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_SQR,
		ST_BLEND,
		ST_FIN
	} state_t;

endpackage

// ----- hw/rtl/bldrv_div.sv -----
module bldrv_div
	import bldrv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PER_W-1:0] num,
	input  logic [PER_W-1:0] den,
	output unit_stat_t       stat,
	output logic [Q_W-1:0]   quot
);

	localparam int STEPS = Q_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] den_q;
	logic [Q_W-1:0]   quot_q;
	logic [PER_W:0]   cand;
	logic [PER_W:0]   diff;
	logic             fits;

	// num never exceeds den, so the first step takes the integer bit without a shift
	always_comb begin
		cand = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff = cand - {1'b0, den_q};
		fits = cand >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[PER_W-1:0] : cand[PER_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quot = quot_q;

endmodule

// ----- hw/rtl/bldrv_mul.sv -----
module bldrv_mul
	import bldrv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output unit_stat_t         stat,
	output logic [MUL_P_W-1:0] prod
);

	// radix-4: two multiplier bits retired per cycle
	localparam int STEPS = MUL_B_W / 2;
	localparam int CNT_W = $clog2(STEPS);
	localparam int HI_W  = MUL_P_W - MUL_B_W;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MUL_A_W-1:0] a_q;
	logic [HI_W-1:0]    hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [MUL_A_W+1:0] pp;
	logic [HI_W+1:0]    sum;

	always_comb begin
		pp  = (lo_q[0] ? {2'b00, a_q} : '0) + (lo_q[1] ? {1'b0, a_q, 1'b0} : '0);
		sum = {2'b00, hi_q} + (HI_W + 2)'(pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// low half doubles as the multiplier shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[HI_W+1:2];
			lo_q <= {sum[1:0], lo_q[MUL_B_W-1:2]};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign prod = {hi_q, lo_q};

endmodule

// ----- hw/rtl/breathing_led_bar_driver_unit.sv -----
// channel | signals                            | transfer when
// --------+------------------------------------+------------------------
// input   | in_valid in_ready now_ms slider_value | in_valid && in_ready
// output  | out_valid out_ready brightness bar_mask | out_valid && out_ready
// config  | cfg_we cfg_index cfg_data          | cfg_we (no back-pressure)
//
// an item on the ramp passes through transfer, evaluate, the bit-serial divider (17 steps)
// that forms the ramp position, the radix-4 multiplier doing the ease square and then the
// blend, and finish; settling and reversal items go from evaluate straight to finish
// one item is worked on at a time; in_ready is high only in idle
// the output register lets the next item start while a result is stalled
// reset loads the register defaults and a rising ramp from 0 to 255
module breathing_led_bar_driver_unit
	import bldrv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic [SLIDER_W-1:0]   slider_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_W-1:0]    brightness,
	output logic [MASK_W-1:0]     bar_mask,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_nxt;

	logic [PER_W-1:0]    settle_q, slow_q, mid_q, fast_q;
	logic [SLIDER_W-1:0] mid_th_q, hi_th_q;

	logic                settling_q;
	logic [SLIDER_W-1:0] held_q;
	logic [NOW_W-1:0]    change_q;
	logic [NOW_W-1:0]    start_q;
	logic [PER_W-1:0]    period_q;
	logic [LEVEL_W-1:0]  from_q, to_q;

	logic [NOW_W-1:0]    now_q;
	logic [SLIDER_W-1:0] n_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                upper_q;

	logic                out_valid_q;
	logic [LEVEL_W-1:0]  brightness_q;
	logic [MASK_W-1:0]   bar_mask_q;

	logic [NOW_W-1:0]    elapsed, since_change;
	logic                changed, ramp_over, settle_over;
	logic [PER_W-1:0]    pick;
	logic                take_in, load_out;

	logic                div_start, mul_start;
	unit_stat_t          div_stat, mul_stat;
	logic [Q_W-1:0]      quot;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  prod;

	logic [PER_W-1:0]    u;
	logic                upper;
	logic [Q_W-1:0]      sq_shr, ease;
	logic                rising;
	logic [LEVEL_W-1:0]  diff;
	logic [LEVEL_W:0]    drop;
	logic [LEVEL_W-1:0]  blend;
	logic [MASK_W-1:0]   mask;

	always_comb begin
		elapsed      = now_q - start_q;
		since_change = now_q - change_q;
		changed      = n_q != held_q;
		ramp_over    = (elapsed[NOW_W-1:PER_W] != '0) || (elapsed[PER_W-1:0] > period_q);
		settle_over  = since_change > {{(NOW_W-PER_W){1'b0}}, settle_q};
		pick         = slow_q;
		if (held_q > mid_th_q) begin
			pick = (held_q > hi_th_q) ? fast_q : mid_q;
		end
		if (pick == '0) begin
			pick = PER_W'(1);
		end
	end

	// ease and blend arithmetic around the shared multiplier
	always_comb begin
		upper  = quot[Q_W-1:Q_W-2] != 2'b00;
		u      = PER_W'(Q_ONE - quot);
		sq_shr = prod[Q_W+14:15];
		ease   = upper_q ? Q_ONE - sq_shr : sq_shr;
		rising = to_q >= from_q;
		diff   = rising ? to_q - from_q : from_q - to_q;
		drop   = {1'b0, prod[23:16]} + {{LEVEL_W{1'b0}}, prod[15:0] != '0};
		blend  = rising ? from_q + prod[23:16] : LEVEL_W'({1'b0, from_q} - drop);
	end

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			mask[i] = (i < NUM_BARS) && (SLIDER_W'(i) <= n_q);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_EVAL;
			ST_EVAL:  state_nxt = (!settling_q && !changed && !ramp_over) ? ST_DIV : ST_FIN;
			ST_DIV:   if (div_stat.done) state_nxt = ST_SQR;
			ST_SQR:   if (mul_stat.done) state_nxt = ST_BLEND;
			ST_BLEND: if (mul_stat.done) state_nxt = ST_FIN;
			ST_FIN:   if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_EVAL:  div_start = !settling_q && !changed && !ramp_over;
			ST_DIV: begin
				mul_start = div_stat.done;
				mul_a     = {1'b0, upper ? u : quot[PER_W-1:0]};
				mul_b     = {2'b00, upper ? u : quot[PER_W-1:0]};
			end
			ST_SQR: begin
				mul_start = mul_stat.done;
				mul_a     = ease;
				mul_b     = {{(MUL_B_W-LEVEL_W){1'b0}}, diff};
			end
			ST_BLEND: ;
			ST_FIN:   load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign take_in = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RST;
			slow_q   <= SLOW_RST;
			mid_q    <= MID_RST;
			fast_q   <= FAST_RST;
			mid_th_q <= MID_TH_RST;
			hi_th_q  <= HI_TH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SETTLE: settle_q <= cfg_data;
				CFG_SLOW:   slow_q   <= cfg_data;
				CFG_MID:    mid_q    <= cfg_data;
				CFG_FAST:   fast_q   <= cfg_data;
				CFG_MID_TH: mid_th_q <= cfg_data[SLIDER_W-1:0];
				CFG_HI_TH:  hi_th_q  <= cfg_data[SLIDER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settling_q <= 1'b0;
			held_q     <= '0;
			change_q   <= '0;
			start_q    <= '0;
			period_q   <= SLOW_RST;
			from_q     <= LEVEL_MIN;
			to_q       <= LEVEL_MAX;
		end else if (state_q == ST_EVAL) begin
			if (changed) begin
				settling_q <= 1'b1;
				held_q     <= n_q;
				change_q   <= now_q;
			end else if (settling_q) begin
				if (settle_over) begin
					settling_q <= 1'b0;
					start_q    <= now_q;
					period_q   <= pick;
					from_q     <= LEVEL_MAX;
					to_q       <= LEVEL_MIN;
				end
			end else if (ramp_over) begin
				// direction reversal
				from_q   <= to_q;
				to_q     <= from_q;
				start_q  <= now_q;
				period_q <= pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			now_q <= now_ms;
			n_q   <= slider_value;
		end
		if (state_q == ST_EVAL) begin
			level_q <= (!settling_q && !changed && ramp_over) ? to_q : LEVEL_MAX;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			upper_q <= upper;
		end
		if (state_q == ST_BLEND && mul_stat.done) begin
			level_q <= blend;
		end
		if (load_out) begin
			brightness_q <= level_q;
			bar_mask_q   <= mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	bldrv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed[PER_W-1:0]),
		.den    (period_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	bldrv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (prod)
	);

	assign out_valid  = out_valid_q;
	assign brightness = brightness_q;
	assign bar_mask   = bar_mask_q;

endmodule

// ----- bench/bldrv_checker.sv -----
module bldrv_checker
	import bldrv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic [SLIDER_W-1:0]   slider_value,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [LEVEL_W-1:0]    brightness,
	input  logic [MASK_W-1:0]     bar_mask,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    failures,
	output int                    pending
);

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [MASK_W-1:0]  mask;
	} bar_frame_t;

	// shadow of the register file
	logic [PER_W-1:0]    settle_r, slow_r, mid_r, fast_r;
	logic [SLIDER_W-1:0] mid_th_r, hi_th_r;

	// shadow of the breathing state
	logic                settling;
	logic [SLIDER_W-1:0] held;
	logic [NOW_W-1:0]    change_at, ramp_t0;
	logic [PER_W-1:0]    ramp_len;
	logic [LEVEL_W-1:0]  ramp_from, ramp_to;

	bar_frame_t frames_due[$];
	int errs;

	function automatic logic [PER_W-1:0] period_for(logic [SLIDER_W-1:0] pos);
		logic [PER_W-1:0] p;
		p = slow_r;
		if (pos > mid_th_r) begin
			p = mid_r;
			if (pos > hi_th_r)
				p = fast_r;
		end
		return (p == '0) ? PER_W'(1) : p;
	endfunction

	// quadratic ease-in-out on a Q1.16 position, 1.0 inclusive
	function automatic logic [16:0] ease_in_out(logic [16:0] t);
		logic [33:0] sq;
		logic [16:0] u;
		if (t < 17'd32768) begin
			sq = 34'(t) * 34'(t) * 34'd2;
			return 17'(sq >> 16);
		end
		u = 17'd65536 - t;
		sq = 34'(u) * 34'(u) * 34'd2;
		return 17'd65536 - 17'(sq >> 16);
	endfunction

	function automatic logic [LEVEL_W-1:0] ramp_level_at(logic [NOW_W-1:0] now);
		logic [NOW_W-1:0]   el;
		logic [LEVEL_W-1:0] tmp;
		logic [16:0]        t, e;
		logic [63:0]        num;
		el = now - ramp_t0;
		if (el > NOW_W'(ramp_len)) begin
			// half-cycle over: swap ends and restart from the far end
			tmp = ramp_from;
			ramp_from = ramp_to;
			ramp_to = tmp;
			ramp_t0 = now;
			ramp_len = period_for(held);
			return ramp_from;
		end
		t = 17'(({32'd0, el} << 16) / 64'(ramp_len));
		e = ease_in_out(t);
		if (ramp_to >= ramp_from) begin
			num = 64'(ramp_to - ramp_from) * 64'(e);
			return ramp_from + LEVEL_W'(num >> 16);
		end
		// falling ramp: round the step up so the level floors
		num = 64'(ramp_from - ramp_to) * 64'(e) + 64'd65535;
		return ramp_from - LEVEL_W'(num >> 16);
	endfunction

	function automatic bar_frame_t drive_bar(logic [NOW_W-1:0] now, logic [SLIDER_W-1:0] pos);
		bar_frame_t f;
		f.level = LEVEL_MAX;
		if (!settling) begin
			if (pos != held) begin
				settling = 1'b1;
				held = pos;
				change_at = now;
			end else begin
				f.level = ramp_level_at(now);
			end
		end else if (pos != held) begin
			held = pos;
			change_at = now;
		end else if (NOW_W'(now - change_at) > NOW_W'(settle_r)) begin
			settling = 1'b0;
			ramp_t0 = now;
			ramp_len = period_for(held);
			ramp_from = LEVEL_MAX;
			ramp_to = LEVEL_MIN;
		end
		f.mask = '0;
		for (int i = 0; i < NUM_BARS && i < MASK_W; i++)
			if (i <= pos)
				f.mask[i] = 1'b1;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bar_frame_t want;
		if (!arst_n) begin
			settle_r = SETTLE_RST;
			slow_r = SLOW_RST;
			mid_r = MID_RST;
			fast_r = FAST_RST;
			mid_th_r = MID_TH_RST;
			hi_th_r = HI_TH_RST;
			settling = 1'b0;
			held = '0;
			change_at = '0;
			ramp_t0 = '0;
			ramp_len = SLOW_RST;
			ramp_from = LEVEL_MIN;
			ramp_to = LEVEL_MAX;
			frames_due.delete();
			errs = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SETTLE: settle_r = cfg_data;
					CFG_SLOW:   slow_r = cfg_data;
					CFG_MID:    mid_r = cfg_data;
					CFG_FAST:   fast_r = cfg_data;
					CFG_MID_TH: mid_th_r = cfg_data[SLIDER_W-1:0];
					CFG_HI_TH:  hi_th_r = cfg_data[SLIDER_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				frames_due.push_back(drive_bar(now_ms, slider_value));
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					$error("unexpected result transfer: brightness %0d bar_mask %h",
						brightness, bar_mask);
					errs++;
				end else begin
					want = frames_due.pop_front();
					if (brightness !== want.level) begin
						$error("brightness expected %0d actual %0d", want.level, brightness);
						errs++;
					end
					if (bar_mask !== want.mask) begin
						$error("bar_mask expected %h actual %h", want.mask, bar_mask);
						errs++;
					end
				end
			end
			failures <= errs;
			pending <= frames_due.size();
		end
	end

endmodule

// ----- bench/tb_breathing_led_bar_driver_unit.sv -----
module tb_breathing_led_bar_driver_unit;
	import bldrv_pkg::*;

	localparam int LIMIT_CYCLES = 500_000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [NOW_W-1:0]      now_ms = '0;
	logic [SLIDER_W-1:0]   slider_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [LEVEL_W-1:0]    brightness;
	logic [MASK_W-1:0]     bar_mask;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    failures;
	int                    pending;

	// stimulus context shared by the tasks and the sink process
	logic [NOW_W-1:0]    clock_ms = '0;
	logic [SLIDER_W-1:0] pos = '0;
	int unsigned         span_ms = 1000;
	bit                  in_rush = 1'b0;
	bit                  out_rush = 1'b0;
	int                  samples_sent = 0;
	int                  slider_moves = 0;
	int                  settings_loaded = 0;

	always #6 clk = ~clk;

	breathing_led_bar_driver_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_ms       (now_ms),
		.slider_value (slider_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.brightness   (brightness),
		.bar_mask     (bar_mask),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	bldrv_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_ms       (now_ms),
		.slider_value (slider_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.brightness   (brightness),
		.bar_mask     (bar_mask),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.pending      (pending)
	);

	// sink side: random stall before each result, with runs of none
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				out_rush = !out_rush;
			stall = out_rush ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
		end
	end

	// valid stays up across back-to-back transfers, so it is only lowered before a gap
	task automatic offer_sample(input logic [NOW_W-1:0] t_ms, input logic [SLIDER_W-1:0] p);
		int gap;
		if ($urandom_range(0, 29) == 0)
			in_rush = !in_rush;
		gap = in_rush ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t_ms;
		slider_value <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// hold off until every result is back and the block has gone quiet
	task automatic quiesce();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (48) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_regs(input logic [PER_W-1:0] settle, input logic [PER_W-1:0] slow,
			input logic [PER_W-1:0] mid, input logic [PER_W-1:0] fast,
			input logic [SLIDER_W-1:0] mid_th, input logic [SLIDER_W-1:0] hi_th);
		put_reg(CFG_SETTLE, settle);
		put_reg(CFG_SLOW, slow);
		put_reg(CFG_MID, mid);
		put_reg(CFG_FAST, fast);
		put_reg(CFG_MID_TH, CFG_DATA_W'(mid_th));
		put_reg(CFG_HI_TH, CFG_DATA_W'(hi_th));
		// unmapped indexes must leave everything alone
		put_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
		put_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		span_ms = 32'(settle);
		if (slow > span_ms) span_ms = 32'(slow);
		if (mid > span_ms) span_ms = 32'(mid);
		if (fast > span_ms) span_ms = 32'(fast);
		if (span_ms < 4) span_ms = 4;
		settings_loaded++;
	endtask

	function automatic logic [PER_W-1:0] any_period();
		return ($urandom_range(0, 7) == 0) ? PER_W'(0) : PER_W'($urandom_range(1, 2000));
	endfunction

	// mostly a steady slider with time moving forward at the scale of the periods
	task automatic random_run(input int count);
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 15))
				0:       ;
				10, 11, 12, 13: clock_ms += $urandom_range(0, span_ms + 1);
				14:      clock_ms += $urandom_range(span_ms, 2 * span_ms + 2);
				15:      clock_ms = $urandom;
				default: clock_ms += $urandom_range(0, span_ms / 8 + 1);
			endcase
			if ($urandom_range(0, 9) == 0) begin
				pos = SLIDER_W'($urandom_range(0, 15));
				slider_moves++;
			end
			offer_sample(clock_ms, pos);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: ramp up, ease midpoint, end of ramp and reversal
		offer_sample(32'd0, 4'd0);
		offer_sample(32'd250, 4'd0);
		offer_sample(32'd500, 4'd0);
		offer_sample(32'd1000, 4'd0);
		offer_sample(32'd1001, 4'd0);
		offer_sample(32'd1501, 4'd0);
		// slider moves: settle, move again while settling, settle boundary
		offer_sample(32'd1501, 4'd15);
		offer_sample(32'd1800, 4'd9);
		offer_sample(32'd2300, 4'd9);
		offer_sample(32'd2301, 4'd9);
		offer_sample(32'd2426, 4'd9);
		offer_sample(32'd2551, 4'd9);
		offer_sample(32'd2552, 4'd9);
		// timestamp wraps through zero mid ramp
		offer_sample(32'hFFFF_FFF0, 4'd9);
		offer_sample(32'h0000_0050, 4'd9);
		// mid and slow period selection by threshold
		offer_sample(32'd80, 4'd7);
		offer_sample(32'd581, 4'd7);
		offer_sample(32'd881, 4'd7);
		offer_sample(32'd881, 4'd6);
		offer_sample(32'd1382, 4'd6);
		offer_sample(32'd2382, 4'd6);
		offer_sample(32'd2383, 4'd6);
		offer_sample(32'd2383, 4'd3);
		clock_ms = 32'd2383;
		pos = 4'd3;
		random_run(80);

		quiesce();
		load_regs(16'd0, 16'd1, 16'd1, 16'd1, 4'd0, 4'd0);
		clock_ms = 32'hFFFF_FF00;
		random_run(90);

		quiesce();
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF);
		clock_ms = 32'hFFF0_0000;
		random_run(90);

		// zero periods behave as one millisecond
		quiesce();
		load_regs(PER_W'($urandom_range(0, 300)), 16'd0, 16'd0, 16'd0,
			SLIDER_W'($urandom_range(0, 15)), SLIDER_W'($urandom_range(0, 15)));
		random_run(90);

		repeat (3) begin
			quiesce();
			load_regs(PER_W'($urandom_range(0, 1500)), any_period(), any_period(), any_period(),
				SLIDER_W'($urandom_range(0, 15)), SLIDER_W'($urandom_range(0, 15)));
			random_run(85);
		end

		quiesce();
		$display("run covered %0d samples with %0d random slider moves", samples_sent,
			slider_moves);
		$display("across reset values and %0d register settings, timestamp wrap included",
			settings_loaded);
		if (failures == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
